FILE: rtl/elevator_disk_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elevator disk scheduler
// Clocked, reset-gated assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_DISK_SCHEDULER_CORE_DEFINES_SVH
`define ELEVATOR_DISK_SCHEDULER_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define EDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true out of reset
`define EDS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Sizes and state encoding of the elevator disk scheduler.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int MAX_REQ = 64;
  localparam int ADDR_W  = $clog2(MAX_REQ);
  localparam int CNT_W   = $clog2(MAX_REQ + 1);
  localparam int TRACK_W = 16;
  localparam int TOTAL_W = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PLACE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

FILE: rtl/eds_ram.sv
// ----------------------------------------------------------------------------
// eds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module eds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/elevator_disk_scheduler_core.sv
// ----------------------------------------------------------------------------
// elevator_disk_scheduler_core
// LOOK scheduling of one batch of track requests held in a sorted RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | side bits
//  ---------+-----+--------------------------------------------+-----------------
//  s_axis   | in  | track[15:0]                                | tlast = last
//  m_axis   | out | served_track, move_distance, total[16:0]   | tlast = end,
//           |     |                                            | tuser = overflow
//  cfg      | in  | head_start[15:0], written when cfg_we      |
//
//  An arriving request is inserted by walking the sorted RAM one entry per
//  cycle through its single read port. The last request then searches for
//  the turn point, reading and then comparing each entry, and each result is
//  read and then loaded into the output register, waiting while it is full.
//  Reset clears the entry count and overflow flag; RAM contents are not reset.
//  Input is taken only in the idle state; results wait in the output register.
// ----------------------------------------------------------------------------
`include "elevator_disk_scheduler_core_defines.svh"

module elevator_disk_scheduler_core
  import eds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // track[15:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // served_track[15:0], move_distance[31:16],
                                 // move_total[48:32], zero pad[55:49]
  output logic        m_tlast,
  output logic        m_tuser    // overflow
);

  state_t state, state_next;

  logic [TRACK_W-1:0] head_start;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               ovf, ovf_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]   split, split_next;
  logic               dir_up, dir_up_next;
  logic               last_hold, last_hold_next;
  logic [TRACK_W-1:0] trk, trk_next;
  logic [TRACK_W-1:0] cur, cur_next;
  logic [TOTAL_W-1:0] total, total_next;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [TRACK_W-1:0] ram_wdata, ram_rdata;

  logic               out_free, out_load, out_end;
  logic [TRACK_W-1:0] move_dist;
  logic [TOTAL_W-1:0] out_total;

  logic [TRACK_W-1:0] o_track, o_dist;
  logic [TOTAL_W-1:0] o_total;
  logic               o_ovf, o_end;

  eds_ram #(.WIDTH(TRACK_W), .DEPTH(MAX_REQ)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign move_dist = (ram_rdata >= cur) ? ram_rdata - cur : cur - ram_rdata;
  assign out_total = total + {1'b0, move_dist};

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ovf_next       = ovf;
    ptr_next       = ptr;
    split_next     = split;
    dir_up_next    = dir_up;
    last_hold_next = last_hold;
    trk_next       = trk;
    cur_next       = cur;
    total_next     = total;
    ram_we         = 1'b0;
    ram_waddr      = ptr[ADDR_W-1:0];
    ram_wdata      = trk;
    ram_re         = 1'b0;
    ram_raddr      = ptr[ADDR_W-1:0];
    out_load       = 1'b0;
    out_end        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          trk_next       = s_tdata;
          last_hold_next = s_tlast;
          ptr_next       = '0;
          if (cnt == CNT_W'(MAX_REQ)) begin
            // store full: drop the request
            ovf_next = 1'b1;
            if (s_tlast) begin
              state_next = ST_FIND_RD;
            end
          end else if (cnt == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = s_tdata;
            cnt_next  = cnt + CNT_W'(1);
            if (s_tlast) begin
              state_next = ST_FIND_RD;
            end
          end else begin
            ptr_next   = cnt;
            ram_re     = 1'b1;
            ram_raddr  = ADDR_W'(cnt - CNT_W'(1));
            state_next = ST_INS;
          end
        end
      end

      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[ADDR_W-1:0];
        if (ram_rdata > trk) begin
          // shift the larger entry up one place
          ram_wdata = ram_rdata;
          ptr_next  = ptr - CNT_W'(1);
          if (ptr == CNT_W'(1)) begin
            state_next = ST_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(ptr - CNT_W'(2));
          end
        end else begin
          ram_wdata  = trk;
          cnt_next   = cnt + CNT_W'(1);
          ptr_next   = '0;
          state_next = last_hold ? ST_FIND_RD : ST_IDLE;
        end
      end

      ST_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = trk;
        cnt_next   = cnt + CNT_W'(1);
        ptr_next   = '0;
        state_next = last_hold ? ST_FIND_RD : ST_IDLE;
      end

      ST_FIND_RD: begin
        if (cnt == '0) begin
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_FIND_CMP;
        end
      end

      ST_FIND_CMP: begin
        cur_next   = head_start;
        total_next = '0;
        if (ram_rdata < head_start && (ptr + CNT_W'(1)) < cnt) begin
          ptr_next   = ptr + CNT_W'(1);
          state_next = ST_FIND_RD;
        end else begin
          split_next = (ram_rdata < head_start) ? cnt : ptr;
          if (split_next < cnt) begin
            ptr_next    = split_next;
            dir_up_next = 1'b1;
          end else begin
            ptr_next    = split_next - CNT_W'(1);
            dir_up_next = 1'b0;
          end
          state_next = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        ram_re     = 1'b1;
        state_next = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (out_free) begin
          out_load   = 1'b1;
          cur_next   = ram_rdata;
          total_next = out_total;
          state_next = ST_EMIT_RD;
          if (dir_up) begin
            if ((ptr + CNT_W'(1)) < cnt) begin
              ptr_next = ptr + CNT_W'(1);
            end else if (split != '0) begin
              // turn at the largest request
              ptr_next    = split - CNT_W'(1);
              dir_up_next = 1'b0;
            end else begin
              out_end = 1'b1;
            end
          end else if (ptr != '0) begin
            ptr_next = ptr - CNT_W'(1);
          end else begin
            out_end = 1'b1;
          end
          if (out_end) begin
            cnt_next   = '0;
            ovf_next   = 1'b0;
            ptr_next   = '0;
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_start <= '0;
      cnt        <= '0;
      ovf        <= 1'b0;
      ptr        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      ptr   <= ptr_next;
      if (cfg_we) begin
        head_start <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    split     <= split_next;
    dir_up    <= dir_up_next;
    last_hold <= last_hold_next;
    trk       <= trk_next;
    cur       <= cur_next;
    total     <= total_next;
    if (out_load) begin
      o_track <= ram_rdata;
      o_dist  <= move_dist;
      o_total <= out_total;
      o_ovf   <= ovf;
      o_end   <= out_end;
    end
  end

  assign m_tdata = {7'd0, o_total, o_dist, o_track};
  assign m_tlast = o_end;
  assign m_tuser = o_ovf;

  `EDS_ASSERT(a_cnt_bound, cnt <= CNT_W'(MAX_REQ), "entry count beyond capacity")
  `EDS_ASSERT_NEVER(a_ram_collide, ram_we && ram_re && ram_waddr == ram_raddr,
                    "read and write of the same entry in one cycle")
  `EDS_ASSERT(a_end_clears, out_load && out_end |=> cnt == '0 && !ovf,
              "batch state not cleared after the final result")
  `EDS_ASSERT(a_ovf_full, $rose(ovf) |-> cnt == CNT_W'(MAX_REQ),
              "overflow flagged with room left in the store")
  `EDS_ASSERT_NEVER(a_load_busy, out_load && m_tvalid && !m_tready,
                    "result loaded over one still waiting")

endmodule
